// ===== design/depth_tested_pixel_store_assert.svh =====
// Assertion macros for the depth-tested pixel store.
// Included by the top level; no other dependencies.
`ifndef DEPTH_TESTED_PIXEL_STORE_ASSERT_SVH
`define DEPTH_TESTED_PIXEL_STORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DTPS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define DTPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/dtps_pkg.sv =====
// Shared types, codes and the decimal digit table of the depth-tested pixel store.
// No dependencies.
package dtps_pkg;

  localparam int MaxWidthDef  = 64;
  localparam int MaxHeightDef = 32;
  localparam int DepthBitsDef = 16;

  localparam int CfgAddrW  = 3;
  localparam int InTdataW  = 40;
  localparam int OutTdataW = 24;

  localparam logic [6:0] FRAME_WIDTH_RST  = 7'd64;
  localparam logic [5:0] FRAME_HEIGHT_RST = 6'd32;

  // register index, taken from paddr[2]
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam logic [1:0] OP_PLOT  = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [2:0] ST_WRITTEN = 3'd0;
  localparam logic [2:0] ST_HIDDEN  = 3'd1;
  localparam logic [2:0] ST_RANGE   = 3'd2;
  localparam logic [2:0] ST_CLEARED = 3'd3;
  localparam logic [2:0] ST_READ    = 3'd4;

  typedef struct packed {
    logic capture;  // latch the accepted transaction
    logic look;     // read the store at the latched address
    logic finish;   // commit the write and load the result register
    logic sweep;    // zero one store entry
  } dtps_cmd_t;

  typedef struct packed {
    logic       sweep_done;
    logic       out_free;
    logic [1:0] in_op;
  } dtps_stat_t;

  // {hundreds, tens, ones} as 6-bit ASCII for every byte value
  typedef logic [255:0][17:0] digit_tab_t;

  function automatic digit_tab_t build_digits();
    digit_tab_t tab;
    int h;
    int t;
    int o;
    h = 0;
    t = 0;
    o = 0;
    for (int i = 0; i < 256; i++) begin
      tab[i] = {6'(48 + h), 6'(48 + t), 6'(48 + o)};
      o++;
      if (o == 10) begin
        o = 0;
        t++;
        if (t == 10) begin
          t = 0;
          h++;
        end
      end
    end
    return tab;
  endfunction

  localparam digit_tab_t DIGIT_TAB = build_digits();

endpackage

// ===== design/dtps_ctrl.sv =====
// Controller of the depth-tested pixel store: sequences accept, lookup, commit and sweeps.
// Depends on dtps_pkg.
module dtps_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dtps_pkg::dtps_stat_t stat_i,
  output dtps_pkg::dtps_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    S_SWEEP,
    S_IDLE,
    S_LOOK,
    S_EVAL
  } state_e;

  state_e state_q;
  logic   clear_pend_q;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o         = '0;
    cmd_o.capture = (state_q == S_IDLE) && in_valid_i;
    cmd_o.look    = (state_q == S_LOOK);
    cmd_o.finish  = (state_q == S_EVAL) && stat_i.out_free;
    cmd_o.sweep   = (state_q == S_SWEEP);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_SWEEP;
      clear_pend_q <= 1'b0;
    end else begin
      case (state_q)
        S_SWEEP: begin
          if (stat_i.sweep_done) begin
            state_q <= clear_pend_q ? S_EVAL : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            case (stat_i.in_op)
              dtps_pkg::OP_PLOT,
              dtps_pkg::OP_READ: state_q <= S_LOOK;
              dtps_pkg::OP_CLEAR: begin
                state_q      <= S_SWEEP;
                clear_pend_q <= 1'b1;
              end
              default: state_q <= S_EVAL;
            endcase
          end
        end
        S_LOOK: state_q <= S_EVAL;
        S_EVAL: begin
          if (stat_i.out_free) begin
            state_q      <= S_IDLE;
            clear_pend_q <= 1'b0;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/dtps_datapath.sv =====
// Datapath of the depth-tested pixel store: address math, color/depth memory,
// depth test, read pointer and result register. Depends on dtps_pkg.
module dtps_datapath #(
  parameter int MAX_WIDTH  = dtps_pkg::MaxWidthDef,
  parameter int MAX_HEIGHT = dtps_pkg::MaxHeightDef,
  parameter int DEPTH_BITS = dtps_pkg::DepthBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  dtps_pkg::dtps_cmd_t            cmd_i,
  output dtps_pkg::dtps_stat_t           stat_o,
  input  logic [dtps_pkg::InTdataW-1:0]  in_data_i,
  input  logic [1:0]                     in_op_i,
  input  logic [6:0]                     frame_width_i,
  input  logic [5:0]                     frame_height_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [dtps_pkg::OutTdataW-1:0] out_data_o,
  output logic                           out_last_o
);

  localparam int Entries = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW      = $clog2(Entries);
  localparam int TW      = $clog2(Entries + 1);
  localparam int WW      = $clog2(MAX_WIDTH + 1);
  localparam int HW      = $clog2(MAX_HEIGHT + 1);
  localparam int CB      = $clog2(MAX_WIDTH);
  localparam int RB      = $clog2(MAX_HEIGHT);
  localparam int CW      = ((WW > 8) ? WW : 8) + 1;
  localparam int RW      = ((HW > 7) ? HW : 7) + 1;
  localparam int MW      = 8 + DEPTH_BITS;
  localparam longint DMaxL = (64'sd1 <<< (DEPTH_BITS - 1)) - 64'sd1;
  localparam logic signed [15:0] DHi = 16'(DMaxL);
  localparam logic signed [15:0] DLo = 16'(-DMaxL - 64'sd1);

  // payload fields
  logic signed [7:0]  pos_x;
  logic signed [6:0]  pos_y;
  logic [7:0]         pixel_color;
  logic signed [15:0] pixel_depth;

  assign pos_x       = $signed(in_data_i[7:0]);
  assign pos_y       = $signed(in_data_i[14:8]);
  assign pixel_color = in_data_i[22:15];
  assign pixel_depth = $signed(in_data_i[38:23]);

  logic [WW-1:0]              act_w;
  logic [HW-1:0]              act_h;
  logic signed [CW-1:0]       col_c;
  logic signed [RW-1:0]       row_c;
  logic                       in_range_c;
  logic [AW-1:0]              plot_idx_c;
  logic [TW-1:0]              total_c;
  logic [AW-1:0]              rd_addr_c;
  logic                       rd_last_c;
  logic signed [DEPTH_BITS-1:0] depth_fit_c;

  always_comb begin
    if (frame_width_i == '0) begin
      act_w = WW'(1);
    end else if (32'(frame_width_i) > MAX_WIDTH) begin
      act_w = WW'(MAX_WIDTH);
    end else begin
      act_w = WW'(frame_width_i);
    end
    if (frame_height_i == '0) begin
      act_h = HW'(1);
    end else if (32'(frame_height_i) > MAX_HEIGHT) begin
      act_h = HW'(MAX_HEIGHT);
    end else begin
      act_h = HW'(frame_height_i);
    end
  end

  always_comb begin
    col_c = $signed(CW'(act_w >> 1)) + CW'(pos_x);
    row_c = $signed(RW'(act_h >> 1)) - RW'(pos_y);
    in_range_c = !col_c[CW-1] && !row_c[RW-1] &&
                 (col_c < $signed(CW'(act_w))) && (row_c < $signed(RW'(act_h)));
    plot_idx_c = AW'(AW'(row_c[RB-1:0]) * AW'(act_w)) + AW'(col_c[CB-1:0]);
  end

  always_comb begin
    if (DEPTH_BITS >= 16) begin
      depth_fit_c = DEPTH_BITS'(pixel_depth);
    end else if (pixel_depth > DHi) begin
      depth_fit_c = DEPTH_BITS'(DHi);
    end else if (pixel_depth < DLo) begin
      depth_fit_c = DEPTH_BITS'(DLo);
    end else begin
      depth_fit_c = DEPTH_BITS'(pixel_depth);
    end
  end

  logic [AW-1:0] rp_q;

  always_comb begin
    total_c   = TW'(TW'(act_w) * TW'(act_h));
    rd_addr_c = (TW'(rp_q) >= total_c) ? '0 : rp_q;
    rd_last_c = (TW'(rd_addr_c) + TW'(1)) >= total_c;
  end

  // latched transaction
  logic [1:0]                   op_q;
  logic [7:0]                   color_q;
  logic signed [DEPTH_BITS-1:0] depth_q;
  logic [AW-1:0]                addr_q;
  logic                         in_range_q;
  logic                         last_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q       <= in_op_i;
      color_q    <= pixel_color;
      depth_q    <= depth_fit_c;
      in_range_q <= in_range_c;
      last_q     <= rd_last_c;
      addr_q     <= (in_op_i == dtps_pkg::OP_READ) ? rd_addr_c : plot_idx_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q <= '0;
    end else if (cmd_i.capture) begin
      if (in_op_i == dtps_pkg::OP_READ) begin
        rp_q <= rd_last_c ? '0 : rd_addr_c + AW'(1);
      end else if (in_op_i == dtps_pkg::OP_CLEAR) begin
        rp_q <= '0;
      end
    end
  end

  // color and depth share one word: {color, depth}
  logic [MW-1:0] mem [Entries];
  logic [MW-1:0] rdata_q;
  logic [AW-1:0] sweep_q;
  logic          sweep_done_c;
  logic          win_c;

  assign sweep_done_c = (sweep_q == AW'(Entries - 1));
  assign win_c = depth_q > $signed(rdata_q[DEPTH_BITS-1:0]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.sweep) begin
      mem[sweep_q] <= '0;
    end else if (cmd_i.finish && op_q == dtps_pkg::OP_PLOT && in_range_q && win_c) begin
      mem[addr_q] <= {color_q, depth_q};
    end
    if (cmd_i.look) begin
      rdata_q <= mem[addr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0;
    end else if (cmd_i.sweep) begin
      sweep_q <= sweep_done_c ? '0 : sweep_q + AW'(1);
    end
  end

  // result register
  logic        out_valid_q;
  logic [2:0]  status_q;
  logic [17:0] digits_q;
  logic        out_last_q;
  logic [2:0]  status_c;
  logic [17:0] digits_c;
  logic        last_c;

  always_comb begin
    digits_c = '0;
    last_c   = 1'b0;
    case (op_q)
      dtps_pkg::OP_PLOT: begin
        if (!in_range_q) begin
          status_c = dtps_pkg::ST_RANGE;
        end else if (win_c) begin
          status_c = dtps_pkg::ST_WRITTEN;
        end else begin
          status_c = dtps_pkg::ST_HIDDEN;
        end
      end
      dtps_pkg::OP_CLEAR: status_c = dtps_pkg::ST_CLEARED;
      dtps_pkg::OP_READ: begin
        status_c = dtps_pkg::ST_READ;
        digits_c = dtps_pkg::DIGIT_TAB[rdata_q[MW-1:DEPTH_BITS]];
        last_c   = last_q;
      end
      default: status_c = dtps_pkg::ST_RANGE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      status_q   <= status_c;
      digits_q   <= digits_c;
      out_last_q <= last_c;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {3'b000, digits_q[5:0], digits_q[11:6], digits_q[17:12], status_q};
  assign out_last_o  = out_last_q;

  always_comb begin
    stat_o            = '0;
    stat_o.sweep_done = sweep_done_c;
    stat_o.out_free   = !out_valid_q || out_ready_i;
    stat_o.in_op      = in_op_i;
  end

endmodule

// ===== design/depth_tested_pixel_store.sv =====
// Depth-tested pixel store: plot and read pass from accept through lookup to evaluate;
// opcode 3 skips lookup. The result register loads once the output is free.
// Clear sweeps all MAX_WIDTH*MAX_HEIGHT entries: one memory entry is zeroed per cycle.
// After rst_ni the whole store is swept with s_axis_tready low.
// Reset: frame 64 x 32, read pointer 0, output register empty.
// A new transaction is accepted only after the last one has loaded its result.
`include "depth_tested_pixel_store_assert.svh"
module depth_tested_pixel_store #(
  parameter int MAX_WIDTH  = dtps_pkg::MaxWidthDef,
  parameter int MAX_HEIGHT = dtps_pkg::MaxHeightDef,
  parameter int DEPTH_BITS = dtps_pkg::DepthBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // pos_x[7:0], pos_y[14:8], pixel_color[22:15], pixel_depth[38:23], zero[39]
  input  logic [dtps_pkg::InTdataW-1:0]  s_axis_tdata,
  // opcode[1:0]
  input  logic [1:0]                     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // status[2:0], digit_hundreds[8:3], digit_tens[14:9], digit_ones[20:15], zero[23:21]
  output logic [dtps_pkg::OutTdataW-1:0] m_axis_tdata,
  output logic                           m_axis_tlast,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [dtps_pkg::CfgAddrW-1:0]  paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  logic [6:0] frame_width_q;
  logic [5:0] frame_height_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= dtps_pkg::FRAME_WIDTH_RST;
      frame_height_q <= dtps_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        dtps_pkg::REG_FRAME_WIDTH:  frame_width_q  <= pwdata[6:0];
        dtps_pkg::REG_FRAME_HEIGHT: frame_height_q <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      dtps_pkg::REG_FRAME_WIDTH:  prdata = {25'd0, frame_width_q};
      dtps_pkg::REG_FRAME_HEIGHT: prdata = {26'd0, frame_height_q};
      default:                    prdata = '0;
    endcase
  end

  dtps_pkg::dtps_cmd_t  cmd;
  dtps_pkg::dtps_stat_t stat;

  dtps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  dtps_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .DEPTH_BITS (DEPTH_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .in_data_i      (s_axis_tdata),
    .in_op_i        (s_axis_tuser),
    .frame_width_i  (frame_width_q),
    .frame_height_i (frame_height_q),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_data_o     (m_axis_tdata),
    .out_last_o     (m_axis_tlast)
  );

  `DTPS_ASSERT_NEXT(a_clear_blocks_input, clk_i, rst_ni,
    s_axis_tvalid && s_axis_tready && s_axis_tuser == dtps_pkg::OP_CLEAR, !s_axis_tready,
    "input taken right after a clear transaction")
  `DTPS_ASSERT_NEXT(a_finish_loads_result, clk_i, rst_ni, cmd.finish, m_axis_tvalid,
    "finished transaction produced no result")
  `DTPS_ASSERT_NOW(a_last_only_on_read, clk_i, rst_ni, m_axis_tvalid && m_axis_tlast,
    m_axis_tdata[2:0] == dtps_pkg::ST_READ, "last flag on a non-read result")

endmodule

// ===== tb/depth_tested_pixel_store_tb.sv =====
// Testbench for depth_tested_pixel_store: random opcode streams with stalls on both sides,
// checked against a tracker class that mirrors the color, depth and read-pointer state.
// Depends on dtps_pkg and the depth_tested_pixel_store top level.
`timescale 1ns / 1ps

module depth_tested_pixel_store_tb;

  localparam int StoreSize = dtps_pkg::MaxWidthDef * dtps_pkg::MaxHeightDef;
  localparam logic [1:0] OpUnused = 2'd3;
  localparam int PhaseItems = 175;

  typedef struct {
    logic [2:0] status;
    logic [5:0] hund;
    logic [5:0] tens;
    logic [5:0] ones;
    logic       last;
  } pixel_reply_t;

  // Mirrors the frame and depth stores and predicts one reply per transaction.
  class zbuffer_tracker;
    logic [7:0]         color_mem [StoreSize];
    logic signed [15:0] depth_mem [StoreSize];
    int                 next_pixel;
    logic [6:0]         width_reg;
    logic [5:0]         height_reg;
    pixel_reply_t       pending_replies [$];
    int                 fault_count;

    function new();
      wipe();
      width_reg   = dtps_pkg::FRAME_WIDTH_RST;
      height_reg  = dtps_pkg::FRAME_HEIGHT_RST;
      fault_count = 0;
    endfunction

    function void wipe();
      foreach (color_mem[i]) begin
        color_mem[i] = '0;
        depth_mem[i] = '0;
      end
      next_pixel = 0;
    endfunction

    function int cols();
      if (width_reg == 0) return 1;
      if (width_reg > dtps_pkg::MaxWidthDef) return dtps_pkg::MaxWidthDef;
      return int'(width_reg);
    endfunction

    function int rows();
      if (height_reg == 0) return 1;
      if (height_reg > dtps_pkg::MaxHeightDef) return dtps_pkg::MaxHeightDef;
      return int'(height_reg);
    endfunction

    function void write_reg(logic idx, logic [31:0] value);
      if (idx == dtps_pkg::REG_FRAME_WIDTH) width_reg = value[6:0];
      else height_reg = value[5:0];
    endfunction

    function void log_request(logic [1:0] op, logic [dtps_pkg::InTdataW-1:0] data);
      pixel_reply_t       r;
      int                 w;
      int                 h;
      int                 col;
      int                 row;
      int                 idx;
      int                 total;
      int                 p;
      logic signed [15:0] d;
      logic [7:0]         c;
      r = '{dtps_pkg::ST_RANGE, 6'd0, 6'd0, 6'd0, 1'b0};
      w = cols();
      h = rows();
      case (op)
        dtps_pkg::OP_PLOT: begin
          col = w / 2 + int'($signed(data[7:0]));
          row = h / 2 - int'($signed(data[14:8]));
          d   = data[38:23];
          if (col >= 0 && row >= 0 && col < w && row < h) begin
            idx = row * w + col;
            // strictly greater wins; a cleared entry holds depth zero
            if (d > depth_mem[idx]) begin
              color_mem[idx] = data[22:15];
              depth_mem[idx] = d;
              r.status = dtps_pkg::ST_WRITTEN;
            end else begin
              r.status = dtps_pkg::ST_HIDDEN;
            end
          end
        end
        dtps_pkg::OP_CLEAR: begin
          wipe();
          r.status = dtps_pkg::ST_CLEARED;
        end
        dtps_pkg::OP_READ: begin
          total = w * h;
          p = next_pixel;
          // restart when the frame shrank below the pointer
          if (p >= total) p = 0;
          c = color_mem[p];
          r.status = dtps_pkg::ST_READ;
          r.hund = 6'(48 + c / 100);
          r.tens = 6'(48 + (c / 10) % 10);
          r.ones = 6'(48 + c % 10);
          if (p + 1 >= total) begin
            r.last = 1'b1;
            next_pixel = 0;
          end else begin
            next_pixel = p + 1;
          end
        end
        default: r.status = dtps_pkg::ST_RANGE;
      endcase
      pending_replies.push_back(r);
    endfunction

    function void flag(string what, int want, int got);
      fault_count++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
    endfunction

    function void compare_reply(logic [dtps_pkg::OutTdataW-1:0] data, logic last);
      pixel_reply_t e;
      if (pending_replies.size() == 0) begin
        flag("unexpected result, status", -1, int'(data[2:0]));
        return;
      end
      e = pending_replies.pop_front();
      if (data[2:0] != e.status) flag("status", e.status, data[2:0]);
      if (data[8:3] != e.hund) flag("digit_hundreds", e.hund, data[8:3]);
      if (data[14:9] != e.tens) flag("digit_tens", e.tens, data[14:9]);
      if (data[20:15] != e.ones) flag("digit_ones", e.ones, data[20:15]);
      if (last != e.last) flag("last_pixel", e.last, last);
    endfunction
  endclass

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              s_axis_tvalid = 1'b0;
  logic                              s_axis_tready;
  logic [dtps_pkg::InTdataW-1:0]     s_axis_tdata = '0;
  logic [1:0]                        s_axis_tuser = dtps_pkg::OP_PLOT;
  logic                              m_axis_tvalid;
  logic                              m_axis_tready = 1'b0;
  logic [dtps_pkg::OutTdataW-1:0]    m_axis_tdata;
  logic                              m_axis_tlast;
  logic                              psel = 1'b0;
  logic                              penable = 1'b0;
  logic                              pwrite = 1'b0;
  logic [dtps_pkg::CfgAddrW-1:0]     paddr = '0;
  logic [31:0]                       pwdata = '0;
  logic [31:0]                       prdata;
  logic                              pready;

  zbuffer_tracker sb;
  bit             quiet = 1'b0;
  int             sink_stall = 0;

  depth_tested_pixel_store dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // result side: random back-pressure bursts
  always @(posedge clk_i) begin
    if (sink_stall > 0) begin
      sink_stall--;
    end else if (!quiet && $urandom_range(0, 11) == 0) begin
      sink_stall = $urandom_range(1, 18) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.compare_reply(m_axis_tdata, m_axis_tlast);
  end

  task automatic apb_write(input logic idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // drop valid and hold until every reply is back and the block takes input again
  task automatic drain_replies();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_replies.size() != 0) @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic set_frame(input int w, input int h);
    drain_replies();
    apb_write(dtps_pkg::REG_FRAME_WIDTH, 32'(w));
    apb_write(dtps_pkg::REG_FRAME_HEIGHT, 32'(h));
  endtask

  task automatic send_item(input logic [1:0] op, input logic [7:0] x, input logic [6:0] y,
                           input logic [7:0] color, input logic [15:0] depth);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {1'b0, depth, color, y, x};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.log_request(op, {1'b0, depth, color, y, x});
  endtask

  task automatic plot(input int x, input int y, input logic [7:0] color, input int depth);
    send_item(dtps_pkg::OP_PLOT, 8'(x), 7'(y), color, 16'(depth));
  endtask

  task automatic random_item();
    int          w;
    int          h;
    int          col;
    int          row;
    int          pick;
    logic [1:0]  op;
    logic [7:0]  x;
    logic [6:0]  y;
    logic [15:0] d;
    w    = sb.cols();
    h    = sb.rows();
    pick = $urandom_range(0, 99);
    op   = dtps_pkg::OP_PLOT;
    col  = $urandom_range(0, w - 1);
    row  = $urandom_range(0, h - 1);
    x    = 8'($urandom);
    y    = 7'($urandom);
    if (pick < 55) begin
      x = 8'(col - w / 2);
      y = 7'(h / 2 - row);
    end else if (pick < 60) begin
      // just outside one border
      case ($urandom_range(0, 3))
        0: col = -1;
        1: col = w;
        2: row = -1;
        default: row = h;
      endcase
      x = 8'(col - w / 2);
      y = 7'(h / 2 - row);
    end else if (pick < 70) begin
      op = dtps_pkg::OP_PLOT;
    end else if (pick < 92) begin
      op = dtps_pkg::OP_READ;
    end else if (pick < 94) begin
      op = dtps_pkg::OP_CLEAR;
    end else begin
      op = OpUnused;
    end
    case ($urandom_range(0, 3))
      0: d = 16'($urandom);
      1: d = 16'($urandom_range(0, 8));
      2: d = 16'($urandom_range(1, 32767));
      default: d = 16'(0 - $urandom_range(1, 8));
    endcase
    send_item(op, x, y, 8'($urandom), d);
  endtask

  initial begin
    int fw [8];
    int fh [8];
    sb = new();
    fw = '{0, 127, 2, 7, 64, 1, 64, 0};
    fh = '{0, 63, 2, 5, 32, 32, 1, 0};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_frame(64, 32);

    plot(0, 0, 8'd255, 1);
    plot(0, 0, 8'd7, 1);
    plot(0, 0, 8'd9, 32767);
    plot(-32, 16, 8'd128, 256);
    plot(31, -15, 8'd200, 5);
    plot(32, 0, 8'd1, 100);
    plot(-33, 0, 8'd1, 100);
    plot(0, 17, 8'd1, 100);
    plot(0, -16, 8'd1, 100);
    plot(-128, -64, 8'd1, 100);
    plot(127, 63, 8'd1, 100);
    plot(1, 1, 8'd3, -32768);
    plot(2, 2, 8'd3, 0);
    send_item(OpUnused, 8'hFF, 7'h7F, 8'hFF, 16'hFFFF);
    send_item(dtps_pkg::OP_READ, 8'h00, 7'h00, 8'h00, 16'h0000);
    send_item(dtps_pkg::OP_READ, 8'hFF, 7'h7F, 8'hFF, 16'hFFFF);
    send_item(dtps_pkg::OP_READ, 8'h00, 7'h00, 8'h00, 16'h0000);
    send_item(dtps_pkg::OP_CLEAR, 8'h00, 7'h00, 8'h00, 16'h0000);
    send_item(dtps_pkg::OP_READ, 8'h00, 7'h00, 8'h00, 16'h0000);
    plot(-32, 16, 8'd42, 1);
    send_item(dtps_pkg::OP_READ, 8'h00, 7'h00, 8'h00, 16'h0000);

    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 7) begin
        fw[ph] = $urandom_range(0, 127);
        fh[ph] = $urandom_range(0, 63);
      end
      set_frame(fw[ph], fh[ph]);
      quiet = (ph == 3) || (ph == 7);
      for (int n = 0; n < PhaseItems; n++) begin
        if (n == 90) drain_replies();
        random_item();
      end
    end

    s_axis_tvalid <= 1'b0;
    while (sb.pending_replies.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.pending_replies.size() != 0)
      sb.flag("replies outstanding", 0, sb.pending_replies.size());
    if (sb.fault_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #1_500_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/dtps_pkg.sv
design/dtps_ctrl.sv
design/dtps_datapath.sv
design/depth_tested_pixel_store.sv
tb/depth_tested_pixel_store_tb.sv
